### sv/iss_pkg.sv
// shared codes and field widths for the indexed sequence store
package iss_pkg;

  localparam int unsigned DEPTH   = 64;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned STAT_W  = 2;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [STAT_W-1:0]  status_t;

  localparam func_t FUNC_ADD_FRONT = 3'd0;
  localparam func_t FUNC_ADD_BACK  = 3'd1;
  localparam func_t FUNC_REMOVE    = 3'd2;
  localparam func_t FUNC_READ      = 3'd3;
  localparam func_t FUNC_WRITE     = 3'd4;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_FULL    = 2'd1;
  localparam status_t STATUS_BAD_POS = 2'd2;

endpackage

### sv/indexed_sequence_store.sv
// ring-buffer sequence store with front/back add, indexed read, write and remove
// add, overwrite and unused codes answer from the execute state; a read also passes a read-wait state
// remove at position p moves each later element down one slot: one memory read and one
// write per moved element, overlapped through the single-port-read element memory
// throughput: one request at a time, busy high from accept until the result cycle; no stall
// synchronous active-low reset empties the store; element memory is not cleared
module indexed_sequence_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  iss_pkg::func_t         in_func,
  input  iss_pkg::pos_t          in_position,
  input  logic signed [31:0]     in_item_value,
  output logic                   out_valid,
  output logic signed [31:0]     out_read_value,
  output iss_pkg::len_t          out_length,
  output iss_pkg::status_t       out_status
);

  localparam int unsigned DEPTH = iss_pkg::DEPTH;
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [PW-1:0]          fp_r, fp_nxt;
  logic                   wr_pend_r, wr_pend_nxt;
  logic [CW-1:0]          rd_idx_r, rd_idx_nxt;
  logic [PW-1:0]          wr_idx_r, wr_idx_nxt;

  iss_pkg::func_t         func_r;
  iss_pkg::pos_t          pos_r;
  iss_pkg::value_t        val_r;

  logic                   out_valid_r, out_valid_nxt;
  iss_pkg::value_t        out_rv_r, out_rv_nxt;
  iss_pkg::len_t          out_len_r, out_len_nxt;
  iss_pkg::status_t       out_st_r, out_st_nxt;

  iss_pkg::value_t        mem [DEPTH];
  iss_pkg::value_t        rdata_r;
  logic                   mem_we, mem_re;
  logic [PW-1:0]          mem_wa, mem_ra;
  iss_pkg::value_t        mem_wd;

  logic                   full, pos_ok;
  logic [PW-1:0]          fp_dec;

  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, base} + {1'b0, p};
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign full   = (cnt_r == CW'(DEPTH));
  assign pos_ok = (XW'(pos_r) < XW'(cnt_r));
  assign fp_dec = (fp_r == '0) ? PW'(DEPTH - 1) : fp_r - PW'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fp_nxt        = fp_r;
    wr_pend_nxt   = wr_pend_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    out_valid_nxt = 1'b0;
    out_rv_nxt    = '0;
    out_st_nxt    = iss_pkg::STATUS_OK;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = val_r;
    mem_re        = 1'b0;
    mem_ra        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        unique case (func_r)
          iss_pkg::FUNC_ADD_FRONT: begin
            if (full) begin
              out_st_nxt = iss_pkg::STATUS_FULL;
            end else begin
              fp_nxt  = fp_dec;
              mem_we  = 1'b1;
              mem_wa  = fp_dec;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          iss_pkg::FUNC_ADD_BACK: begin
            if (full) begin
              out_st_nxt = iss_pkg::STATUS_FULL;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = slot_of(fp_r, PW'(cnt_r));
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          iss_pkg::FUNC_REMOVE: begin
            if (!pos_ok) begin
              out_st_nxt = iss_pkg::STATUS_BAD_POS;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_SHIFT;
              rd_idx_nxt    = CW'(pos_r) + CW'(1);
              wr_idx_nxt    = PW'(pos_r);
              wr_pend_nxt   = 1'b0;
            end
          end
          iss_pkg::FUNC_READ: begin
            if (!pos_ok) begin
              out_st_nxt = iss_pkg::STATUS_BAD_POS;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_RDWAIT;
              mem_re        = 1'b1;
              mem_ra        = slot_of(fp_r, PW'(pos_r));
            end
          end
          iss_pkg::FUNC_WRITE: begin
            if (!pos_ok) begin
              out_st_nxt = iss_pkg::STATUS_BAD_POS;
            end else begin
              mem_we = 1'b1;
              mem_wa = slot_of(fp_r, PW'(pos_r));
            end
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_rv_nxt    = rdata_r;
      end
      S_SHIFT: begin
        // read element k+1 while writing the one fetched last cycle into slot k
        if (rd_idx_r < cnt_r) begin
          mem_re      = 1'b1;
          mem_ra      = slot_of(fp_r, PW'(rd_idx_r));
          rd_idx_nxt  = rd_idx_r + CW'(1);
        end
        wr_pend_nxt = (rd_idx_r < cnt_r);
        if (wr_pend_r) begin
          mem_we     = 1'b1;
          mem_wa     = slot_of(fp_r, wr_idx_r);
          mem_wd     = rdata_r;
          wr_idx_nxt = wr_idx_r + PW'(1);
        end
        if (!(rd_idx_r < cnt_r)) begin
          state_nxt     = S_IDLE;
          cnt_nxt       = cnt_r - CW'(1);
          out_valid_nxt = 1'b1;
        end
      end
    endcase
    out_len_nxt = iss_pkg::LEN_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fp_r        <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fp_r        <= fp_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      func_r <= in_func;
      pos_r  <= in_position;
      val_r  <= in_item_value;
    end
    rd_idx_r <= rd_idx_nxt;
    wr_idx_r <= wr_idx_nxt;
    if (out_valid_nxt) begin
      out_rv_r  <= out_rv_nxt;
      out_len_r <= out_len_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_ra];
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_length     = out_len_r;
  assign out_status     = out_st_r;

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  a_result_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("block still busy during result cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CW'(DEPTH)) && (fp_r <= PW'(DEPTH - 1)))
    else $error("length or front pointer out of range");

  a_length_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length == $past(out_len_nxt)))
    else $error("reported length does not follow stored count");

endmodule
